// ===== rtl/hkr_pkg.sv =====
// shared types, constants and key map for the keyboard report decoder
package hkr_pkg;

  localparam int SLOT_COUNT = 6;
  localparam int SLOT_IDX_W = 3;
  localparam int TABLE_LEN  = 57;
  localparam logic [7:0] SHIFT_MASK = 8'h22;

  typedef enum logic {
    CMD_REPORT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_e;

  typedef logic [SLOT_COUNT-1:0][7:0] key_arr_t;

  typedef struct packed {
    logic       command;
    logic [7:0] report_modifiers;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } in_req_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       char_valid;
    logic [5:0] chars_waiting;
    logic [7:0] modifiers_held;
  } out_req_t;

  // what one lane found for its slot
  typedef struct packed {
    logic       vld;
    logic [6:0] ch;
  } lane_res_t;

  localparam logic [6:0] PLAIN_MAP [TABLE_LEN] = '{
    7'h00, 7'h00, 7'h00, 7'h00, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66,
    7'h67, 7'h68, 7'h69, 7'h6A, 7'h6B, 7'h6C, 7'h6D, 7'h6E, 7'h6F, 7'h70,
    7'h71, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A,
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20, 7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C,
    7'h23, 7'h3B, 7'h27, 7'h60, 7'h2C, 7'h2E, 7'h2F
  };

  localparam logic [6:0] SHIFT_MAP [TABLE_LEN] = '{
    7'h00, 7'h00, 7'h00, 7'h00, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46,
    7'h47, 7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50,
    7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
    7'h0A, 7'h1B, 7'h08, 7'h09, 7'h20, 7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C,
    7'h7E, 7'h3A, 7'h22, 7'h7E, 7'h3C, 7'h3E, 7'h3F
  };

  function automatic logic [6:0] map_key(input logic [7:0] code, input logic shift);
    logic [6:0] ch;
    ch = 7'd0;
    if (code < 8'(TABLE_LEN)) begin
      ch = shift ? SHIFT_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
    end
    return ch;
  endfunction

endpackage

// ===== rtl/hkr_ram.sv =====
// generic single-port-write ram with registered read
module hkr_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/hkr_lane.sv =====
// one key slot lane: new-press check against previous keys and key map
module hkr_lane (
  input  logic [7:0]        slot_i,
  input  hkr_pkg::key_arr_t prev_i,
  input  logic              shift_i,
  output hkr_pkg::lane_res_t res_o
);
  import hkr_pkg::*;

  logic       seen;
  logic [6:0] ch;

  always_comb begin
    seen = 1'b0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      if (slot_i == prev_i[j]) begin
        seen = 1'b1;
      end
    end
    ch = map_key(slot_i, shift_i);
  end

  // empty slot and unmapped codes give no character
  assign res_o.vld = (slot_i != 8'd0) && !seen && (ch != 7'd0);
  assign res_o.ch  = ch;

endmodule

// ===== rtl/hid_keyboard_report_to_ascii_fifo_unit.sv =====
// top level: boot keyboard report decoder feeding an ascii character fifo
// report request: a lane compare state, then one push per slot through the single
//   fifo write port, then a result state
// pop request: a registered fifo ram read with a character, straight to the result when empty
// one request in flight at a time, next one taken the cycle after its result;
//   a waiting result stalls done
// reset clears previous keys, held modifiers, pointers and fill count;
//   fifo ram contents are not cleared and need no clearing pass
module hid_keyboard_report_to_ascii_fifo_unit #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  hkr_pkg::in_req_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hkr_pkg::out_req_t out_req_o
);
  import hkr_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
  // ring holds one less than its depth
  localparam logic [AW-1:0] FULL_CNT = AW'(FIFO_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_PUSH,
    ST_POP_RD,
    ST_DONE
  } state_e;

  state_e              state_q;
  key_arr_t            prev_q;
  key_arr_t            slot_q;
  logic [7:0]          mods_q;
  logic [AW-1:0]       wp_q;
  logic [AW-1:0]       rp_q;
  logic [AW-1:0]       cnt_q;
  logic [SLOT_IDX_W-1:0] idx_q;
  lane_res_t           lane_q [SLOT_COUNT];
  lane_res_t           lane_res [SLOT_COUNT];
  logic                pop_hit_q;
  logic                out_valid_q;
  out_req_t            out_q;

  logic                shift;
  logic                full;
  logic [AW-1:0]       wp_inc;
  logic [AW-1:0]       rp_inc;
  logic                ram_we;
  logic                ram_re;
  logic [6:0]          ram_rdata;
  logic [AW+5:0]       cnt_ext;
  logic                out_free;
  logic [AW-1:0]       ptr_fill;

  assign shift  = (mods_q & SHIFT_MASK) != 8'd0;
  assign full   = (cnt_q == FULL_CNT);
  assign wp_inc = (wp_q == LAST_IDX) ? '0 : wp_q + AW'(1);
  assign rp_inc = (rp_q == LAST_IDX) ? '0 : rp_q + AW'(1);

  // push one lane result per cycle when it is valid, dropped when the ring is full
  assign ram_we = (state_q == ST_PUSH) && lane_q[idx_q].vld && !full;
  assign ram_re = (state_q == ST_POP_RD);

  // chars_waiting carries the low six bits of the fill level
  assign cnt_ext  = {6'd0, cnt_q};
  assign out_free = !out_valid_q || !out_stall_i;

  // fill level as seen from the pointers, cross-checked against cnt_q
  assign ptr_fill = (wp_q >= rp_q) ? (wp_q - rp_q) : AW'(wp_q + AW'(FIFO_DEPTH) - rp_q);

  // six lanes check their slots side by side
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_lane
    hkr_lane u_lane (
      .slot_i (slot_q[g]),
      .prev_i (prev_q),
      .shift_i(shift),
      .res_o  (lane_res[g])
    );
  end

  hkr_ram #(
    .WIDTH(7),
    .DEPTH(FIFO_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(lane_q[idx_q].ch),
    .re_i   (ram_re),
    .raddr_i(rp_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      slot_q      <= '0;
      mods_q      <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      pop_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        lane_q[i] <= '0;
      end
    end else begin
      // result taken downstream; in done a new result takes its place instead
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (cmd_e'(in_req_i.command) == CMD_POP) begin
              // pop on an empty ring goes straight to the result
              pop_hit_q <= (cnt_q != '0);
              state_q   <= (cnt_q != '0) ? ST_POP_RD : ST_DONE;
            end else begin
              pop_hit_q <= 1'b0;
              mods_q    <= in_req_i.report_modifiers;
              slot_q[0] <= in_req_i.key_slot_0;
              slot_q[1] <= in_req_i.key_slot_1;
              slot_q[2] <= in_req_i.key_slot_2;
              slot_q[3] <= in_req_i.key_slot_3;
              slot_q[4] <= in_req_i.key_slot_4;
              slot_q[5] <= in_req_i.key_slot_5;
              state_q   <= ST_LANE;
            end
          end
        end
        ST_LANE: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            lane_q[i] <= lane_res[i];
          end
          // lanes are captured, so the slots may become the previous keys now
          prev_q  <= slot_q;
          idx_q   <= '0;
          state_q <= ST_PUSH;
        end
        ST_PUSH: begin
          if (ram_we) begin
            wp_q  <= wp_inc;
            cnt_q <= cnt_q + AW'(1);
          end
          if (idx_q == SLOT_IDX_W'(SLOT_COUNT - 1)) begin
            state_q <= ST_DONE;
          end else begin
            idx_q <= idx_q + SLOT_IDX_W'(1);
          end
        end
        ST_POP_RD: begin
          rp_q    <= rp_inc;
          cnt_q   <= cnt_q - AW'(1);
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_q.char_out       <= pop_hit_q ? ram_rdata : 7'd0;
            out_q.char_valid     <= pop_hit_q;
            out_q.chars_waiting  <= cnt_ext[5:0];
            out_q.modifiers_held <= mods_q;
            out_valid_q          <= 1'b1;
            state_q              <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !full)
    else $error("fifo write while full");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("fill count above capacity");

  a_cnt_matches_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == ptr_fill)
    else $error("fill count disagrees with pointers");

  a_pop_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_RD) |=> (cnt_q == $past(cnt_q) - AW'(1)))
    else $error("pop did not lower fill count");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside done state");

endmodule
